// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the checker module of this project.
// Needs nothing else; each macro expands to one labeled concurrent assertion.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/uifa_pkg.sv =====
// Shared types, constants and pair tables of the Fisher accumulator.
// No dependencies; the other RTL files but the checker and its header use scoped names.
`default_nettype none

package uifa_pkg;

  localparam int CONC_W      = 32;  // substrate, inhibitor, parameters
  localparam int WEIGHT_W    = 17;  // Q1.16 weight, up to just under 2.0
  localparam int REG_W       = 32;
  localparam int IDX_W       = 2;
  localparam int WORD_W      = 64;  // muldiv operands and accumulators
  localparam int NUM_ENTRIES = 6;
  localparam int SLOT_W      = 3;
  localparam int NUM_GRAD    = 3;
  localparam int GRAD_IDX_W  = 2;

  localparam logic [IDX_W-1:0] REG_V_MAX     = 2'd0;
  localparam logic [IDX_W-1:0] REG_MICHAELIS = 2'd1;
  localparam logic [IDX_W-1:0] REG_DISSOC    = 2'd2;

  localparam logic [WORD_W-1:0] GRAD_ONE = 64'h0000_0001_0000_0000;
  localparam logic [WORD_W-1:0] WORD_MAX = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [WORD_W-1:0] MAG_MAX  = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [WORD_W-1:0] ACC_MIN  = 64'h8000_0000_0000_0000;

  localparam logic [SLOT_W-1:0] SLOT_FIRST = 3'd0;
  localparam logic [SLOT_W-1:0] SLOT_LAST  = SLOT_W'(NUM_ENTRIES - 1);

  // Muldiv flavors: true divide, or divide by 2^32 / 2^16 as a slice.
  typedef enum logic [1:0] {
    MD_GENERAL,
    MD_SHIFT32,
    MD_SHIFT16
  } md_mode_t;

  typedef struct packed {
    logic     start;
    md_mode_t mode;
  } md_req_t;

  typedef struct packed {
    logic done;
    logic sat;
  } md_rsp_t;

  typedef enum logic [1:0] {
    MDS_IDLE,
    MDS_MUL,
    MDS_CHECK,
    MDS_DIV
  } md_state_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_WAIT,
    ST_DEN,
    ST_CLAMP,
    ST_ACC,
    ST_EMIT
  } seq_state_t;

  typedef enum logic [2:0] {
    OP_Q,
    OP_G0,
    OP_M1,
    OP_M2,
    OP_PAIR,
    OP_TERM
  } op_t;

  typedef struct packed {
    logic              add;
    logic              clr;
    logic              neg;
    logic [SLOT_W-1:0] slot;
  } acc_cmd_t;

  typedef logic [NUM_ENTRIES-1:0][WORD_W-1:0] fisher_t;

  // Slot order: VV, VKm, VKiu, KmKm, KmKiu, KiuKiu.
  function automatic logic [GRAD_IDX_W-1:0] pair_row(input logic [SLOT_W-1:0] slot);
    logic [GRAD_IDX_W-1:0] r;
    case (slot)
      3'd0, 3'd1, 3'd2: r = 2'd0;
      3'd3, 3'd4:       r = 2'd1;
      default:          r = 2'd2;
    endcase
    return r;
  endfunction

  function automatic logic [GRAD_IDX_W-1:0] pair_col(input logic [SLOT_W-1:0] slot);
    logic [GRAD_IDX_W-1:0] c;
    case (slot)
      3'd0:       c = 2'd0;
      3'd1, 3'd3: c = 2'd1;
      default:    c = 2'd2;
    endcase
    return c;
  endfunction

  // d/dKm is negative, the others positive: pairs with one Km factor subtract.
  function automatic logic pair_neg(input logic [SLOT_W-1:0] slot);
    return (slot == 3'd1) || (slot == 3'd4);
  endfunction

endpackage

`default_nettype wire

// ===== rtl/uifa_if.sv =====
// Valid/ready channel interfaces for design points and Fisher results.
// Depends on uifa_pkg for field widths.
`default_nettype none

interface uifa_point_if;
  logic                           valid;
  logic                           ready;
  logic [uifa_pkg::CONC_W-1:0]    substrate;
  logic [uifa_pkg::CONC_W-1:0]    inhibitor;
  logic [uifa_pkg::WEIGHT_W-1:0]  weight;
  logic                           last_point;

  modport source (output valid, substrate, inhibitor, weight, last_point, input ready);
  modport sink   (input valid, substrate, inhibitor, weight, last_point, output ready);
endinterface

interface uifa_fisher_if;
  logic                               valid;
  logic                               ready;
  logic signed [uifa_pkg::WORD_W-1:0] m_vv;
  logic signed [uifa_pkg::WORD_W-1:0] m_vkm;
  logic signed [uifa_pkg::WORD_W-1:0] m_vkiu;
  logic signed [uifa_pkg::WORD_W-1:0] m_kmkm;
  logic signed [uifa_pkg::WORD_W-1:0] m_kmkiu;
  logic signed [uifa_pkg::WORD_W-1:0] m_kiukiu;
  logic                               saturated;

  modport source (output valid, m_vv, m_vkm, m_vkiu, m_kmkm, m_kmkiu, m_kiukiu, saturated,
                  input ready);
  modport sink   (input valid, m_vv, m_vkm, m_vkiu, m_kmkm, m_kmkiu, m_kiukiu, saturated,
                  output ready);
endinterface

`default_nettype wire

// ===== rtl/uncomp_inhibition_fisher_accum.sv =====
// Top level: Fisher information accumulator, uncompetitive inhibition model.
// Depends on uifa_pkg, uifa_if, uifa_muldiv and uifa_accum.
`default_nettype none

// Channel   Dir  Beat payload                                   Sent when
// point     in   substrate, inhibitor, weight, last_point      one design point
// fisher    out  m_vv .. m_kiukiu (Q32.32), saturated          after last_point
// wr_*      in   wr_index, wr_data (V, Km, Kiu in Q16.16)      while idle
//
// A point's work is set by four true divides on the shared muldiv unit, each a
// multiply over four partial products, a range check and, unless it saturates,
// 64 restoring steps; the six pair terms follow.
// point.ready is high only in the idle state; a finished matrix sits in the
// output register, so the next point is taken while fisher is stalled.
// A last point whose matrix finds the output register still full waits there.
// rst is synchronous: accumulators, sticky flag and control clear, and the
// three parameters return to 1.0.

module uncomp_inhibition_fisher_accum #(
  parameter int FRAC_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         wr_en,
  input  logic [uifa_pkg::IDX_W-1:0]   wr_index,
  input  logic [uifa_pkg::REG_W-1:0]   wr_data,
  uifa_point_if.sink                   point,
  uifa_fisher_if.source                fisher
);

  localparam int W = uifa_pkg::WORD_W;
  // 1.0 in the register format
  localparam logic [uifa_pkg::REG_W-1:0] REG_ONE = uifa_pkg::REG_W'(64'd1 << FRAC_BITS);

  uifa_pkg::seq_state_t state, state_next;
  uifa_pkg::op_t        op;
  logic [uifa_pkg::SLOT_W-1:0] slot;

  // parameter registers
  logic [uifa_pkg::REG_W-1:0] v_max, michaelis_const, dissociation_const;

  // current point
  logic [uifa_pkg::CONC_W-1:0]   s_reg, i_reg;
  logic [uifa_pkg::WEIGHT_W-1:0] w_reg;
  logic                          last_reg;

  // intermediates: q = S*I/Kiu, den = Km+S+q, mag = |gradient|
  logic [W-1:0]                               q, den;
  logic [uifa_pkg::NUM_GRAD-1:0][W-1:0]       mag;
  logic                                       sat_flag, sat_set;

  // output register
  logic               res_valid, res_sat;
  uifa_pkg::fisher_t  res_mat;
  logic               emit_go;

  // shared unit and accumulator bank
  uifa_pkg::md_req_t  md_req;
  uifa_pkg::md_rsp_t  md_rsp;
  logic [W-1:0]       md_a, md_b, md_d, md_quo;
  uifa_pkg::acc_cmd_t acc_cmd;
  logic [W-2:0]       term_mag;
  logic               term_clip;
  uifa_pkg::fisher_t  acc_val;
  logic               acc_sat;

  logic [W:0]         den_sum;

  uifa_muldiv u_muldiv (
    .clk (clk),
    .rst (rst),
    .req (md_req),
    .a   (md_a),
    .b   (md_b),
    .d   (md_d),
    .rsp (md_rsp),
    .quo (md_quo)
  );

  uifa_accum u_accum (
    .clk  (clk),
    .rst  (rst),
    .cmd  (acc_cmd),
    .term (term_mag),
    .acc  (acc_val),
    .sat  (acc_sat)
  );

  // ---- configuration writes; indexes past Kiu are dropped ----
  always_ff @(posedge clk) begin
    if (rst) begin
      v_max              <= REG_ONE;
      michaelis_const    <= REG_ONE;
      dissociation_const <= REG_ONE;
    end else if (wr_en) begin
      case (wr_index)
        uifa_pkg::REG_V_MAX:     v_max              <= wr_data;
        uifa_pkg::REG_MICHAELIS: michaelis_const    <= wr_data;
        uifa_pkg::REG_DISSOC:    dissociation_const <= wr_data;
        default: begin
        end
      endcase
    end
  end

  // ---- operand select for the shared unit ----
  always_comb begin
    md_a        = '0;
    md_b        = '0;
    md_d        = '0;
    md_req.mode = uifa_pkg::MD_GENERAL;
    case (op)
      uifa_pkg::OP_Q: begin            // S*I / Kiu
        md_a = W'(s_reg);
        md_b = W'(i_reg);
        md_d = W'(dissociation_const);
      end
      uifa_pkg::OP_G0: begin           // S*2^32 / D
        md_a = W'(s_reg);
        md_b = uifa_pkg::GRAD_ONE;
        md_d = den;
      end
      uifa_pkg::OP_M1: begin           // g0*V / D
        md_a = mag[0];
        md_b = W'(v_max);
        md_d = den;
      end
      uifa_pkg::OP_M2: begin           // m1*q / Kiu, m1 not yet clamped
        md_a = mag[1];
        md_b = q;
        md_d = W'(dissociation_const);
      end
      uifa_pkg::OP_PAIR: begin         // |gr|*|gc| >> 32
        md_a        = mag[uifa_pkg::pair_row(slot)];
        md_b        = mag[uifa_pkg::pair_col(slot)];
        md_req.mode = uifa_pkg::MD_SHIFT32;
      end
      uifa_pkg::OP_TERM: begin         // pair product, still held by the unit, * w >> 16
        md_a        = md_quo;
        md_b        = W'(w_reg);
        md_req.mode = uifa_pkg::MD_SHIFT16;
      end
      default: md_req.mode = uifa_pkg::MD_GENERAL;
    endcase
  end

  // Km + S cannot overflow 33 bits; only adding q can saturate
  assign den_sum   = (W + 1)'(michaelis_const) + (W + 1)'(s_reg) + (W + 1)'(q);
  assign term_clip = md_quo[W-1];
  assign term_mag  = term_clip ? uifa_pkg::MAG_MAX[W-2:0] : md_quo[W-2:0];
  assign emit_go   = !res_valid || fisher.ready;

  // ---- sequencer ----
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= uifa_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next   = state;
    md_req.start = 1'b0;
    acc_cmd      = '0;
    acc_cmd.slot = slot;
    acc_cmd.neg  = uifa_pkg::pair_neg(slot);
    case (state)
      uifa_pkg::ST_IDLE: begin
        if (point.valid) state_next = uifa_pkg::ST_ISSUE;
      end
      uifa_pkg::ST_ISSUE: begin
        md_req.start = 1'b1;
        state_next   = uifa_pkg::ST_WAIT;
      end
      uifa_pkg::ST_WAIT: begin
        if (md_rsp.done) begin
          case (op)
            uifa_pkg::OP_Q:    state_next = uifa_pkg::ST_DEN;
            uifa_pkg::OP_M2:   state_next = uifa_pkg::ST_CLAMP;
            uifa_pkg::OP_TERM: state_next = uifa_pkg::ST_ACC;
            default:           state_next = uifa_pkg::ST_ISSUE;
          endcase
        end
      end
      uifa_pkg::ST_DEN:   state_next = uifa_pkg::ST_ISSUE;
      uifa_pkg::ST_CLAMP: state_next = uifa_pkg::ST_ISSUE;
      uifa_pkg::ST_ACC: begin
        acc_cmd.add = 1'b1;
        if (slot != uifa_pkg::SLOT_LAST) begin
          state_next = uifa_pkg::ST_ISSUE;
        end else if (last_reg) begin
          state_next = uifa_pkg::ST_EMIT;
        end else begin
          state_next = uifa_pkg::ST_IDLE;
        end
      end
      uifa_pkg::ST_EMIT: begin
        if (emit_go) begin
          acc_cmd.clr = 1'b1;
          state_next  = uifa_pkg::ST_IDLE;
        end
      end
      default: state_next = uifa_pkg::ST_IDLE;
    endcase
  end

  // any saturation seen by this step
  always_comb begin
    case (state)
      uifa_pkg::ST_WAIT:  sat_set = md_rsp.done && md_rsp.sat;
      uifa_pkg::ST_DEN:   sat_set = den_sum[W];
      uifa_pkg::ST_CLAMP: sat_set = mag[1][W-1] || mag[2][W-1];
      uifa_pkg::ST_ACC:   sat_set = term_clip || acc_sat;
      default:            sat_set = 1'b0;
    endcase
  end

  // ---- control registers ----
  always_ff @(posedge clk) begin
    if (rst) begin
      op        <= uifa_pkg::OP_Q;
      slot      <= uifa_pkg::SLOT_FIRST;
      sat_flag  <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      case (state)
        uifa_pkg::ST_IDLE: begin
          if (point.valid) op <= uifa_pkg::OP_Q;
        end
        uifa_pkg::ST_WAIT: begin
          if (md_rsp.done) begin
            case (op)
              uifa_pkg::OP_G0:   op <= uifa_pkg::OP_M1;
              uifa_pkg::OP_M1:   op <= uifa_pkg::OP_M2;
              uifa_pkg::OP_PAIR: op <= uifa_pkg::OP_TERM;
              default:           op <= op;
            endcase
          end
        end
        uifa_pkg::ST_DEN: op <= uifa_pkg::OP_G0;
        uifa_pkg::ST_CLAMP: begin
          op   <= uifa_pkg::OP_PAIR;
          slot <= uifa_pkg::SLOT_FIRST;
        end
        uifa_pkg::ST_ACC: begin
          op   <= uifa_pkg::OP_PAIR;
          slot <= slot + 1'b1;
        end
        default: op <= op;
      endcase

      // flag and result handshake
      if (state == uifa_pkg::ST_EMIT && emit_go) begin
        sat_flag  <= 1'b0;
        res_valid <= 1'b1;
      end else begin
        if (sat_set) sat_flag <= 1'b1;
        if (fisher.ready) res_valid <= 1'b0;
      end
    end
  end

  // ---- datapath registers ----
  always_ff @(posedge clk) begin
    case (state)
      uifa_pkg::ST_IDLE: begin
        if (point.valid) begin
          s_reg    <= point.substrate;
          i_reg    <= point.inhibitor;
          w_reg    <= point.weight;
          last_reg <= point.last_point;
        end
      end
      uifa_pkg::ST_WAIT: begin
        if (md_rsp.done) begin
          case (op)
            uifa_pkg::OP_Q:  q      <= md_quo;
            uifa_pkg::OP_G0: mag[0] <= md_quo;
            uifa_pkg::OP_M1: mag[1] <= md_quo;
            uifa_pkg::OP_M2: mag[2] <= md_quo;
            default:         q      <= q;
          endcase
        end
      end
      uifa_pkg::ST_DEN: den <= den_sum[W] ? uifa_pkg::WORD_MAX : den_sum[W-1:0];
      uifa_pkg::ST_CLAMP: begin
        if (mag[1][W-1]) mag[1] <= uifa_pkg::MAG_MAX;
        if (mag[2][W-1]) mag[2] <= uifa_pkg::MAG_MAX;
      end
      uifa_pkg::ST_EMIT: begin
        if (emit_go) begin
          res_mat <= acc_val;
          res_sat <= sat_flag;
        end
      end
      default: den <= den;
    endcase
  end

  // ---- ports ----
  assign point.ready      = (state == uifa_pkg::ST_IDLE);
  assign fisher.valid     = res_valid;
  assign fisher.m_vv      = $signed(res_mat[0]);
  assign fisher.m_vkm     = $signed(res_mat[1]);
  assign fisher.m_vkiu    = $signed(res_mat[2]);
  assign fisher.m_kmkm    = $signed(res_mat[3]);
  assign fisher.m_kmkiu   = $signed(res_mat[4]);
  assign fisher.m_kiukiu  = $signed(res_mat[5]);
  assign fisher.saturated = res_sat;

endmodule

`default_nettype wire

// ===== rtl/uifa_muldiv.sv =====
// Shared muldiv unit: floor(a*b/d), or a*b >> 32 / >> 16, on 64-bit operands, saturating.
// 32x32 multiplier over four partial products, then restoring divider.
// Depends on uifa_pkg.
`default_nettype none

module uifa_muldiv (
  input  logic                        clk,
  input  logic                        rst,
  input  uifa_pkg::md_req_t           req,
  input  logic [uifa_pkg::WORD_W-1:0] a,
  input  logic [uifa_pkg::WORD_W-1:0] b,
  input  logic [uifa_pkg::WORD_W-1:0] d,
  output uifa_pkg::md_rsp_t           rsp,
  output logic [uifa_pkg::WORD_W-1:0] quo
);

  localparam int W    = uifa_pkg::WORD_W;
  localparam int HALF = W / 2;
  localparam logic [2:0] MUL_LAST = 3'd4;
  localparam logic [5:0] DIV_LAST = 6'(W - 1);

  uifa_pkg::md_state_t state, state_next;
  uifa_pkg::md_mode_t  mode;

  logic [W-1:0]      opa, opb, div;
  logic [W-1:0]      hi, lo;      // product; later remainder and quotient
  logic [W-1:0]      pp;
  logic [1:0]        pp_idx;
  logic [2:0]        mcnt;
  logic [5:0]        dcnt;

  logic [HALF-1:0]   ah, bh;
  logic [W-1:0]      pp_prod;
  logic [2*W-1:0]    pp_wide;
  logic              div_needed, chk_sat;
  logic [W-1:0]      chk_quo;
  logic [W-1:0]      shifted;
  logic [W+1:0]      diff;
  logic              ge;

  // partial product a_i * b_j, i = mcnt[0], j = mcnt[1]
  assign ah      = mcnt[0] ? opa[W-1:HALF] : opa[HALF-1:0];
  assign bh      = mcnt[1] ? opb[W-1:HALF] : opb[HALF-1:0];
  assign pp_prod = ah * bh;

  always_comb begin
    case (pp_idx)
      2'd0:    pp_wide = {{W{1'b0}}, pp};
      2'd3:    pp_wide = {pp, {W{1'b0}}};
      default: pp_wide = {{HALF{1'b0}}, pp, {HALF{1'b0}}};
    endcase
  end

  // range check after the product is complete
  always_comb begin
    chk_sat = 1'b0;
    chk_quo = '0;
    case (mode)
      uifa_pkg::MD_GENERAL: begin
        chk_sat = (div == '0) ? ((hi | lo) != '0) : (hi >= div);
        chk_quo = chk_sat ? uifa_pkg::WORD_MAX : '0;
      end
      uifa_pkg::MD_SHIFT32: begin
        chk_sat = hi[W-1:HALF] != '0;
        chk_quo = chk_sat ? uifa_pkg::WORD_MAX : {hi[HALF-1:0], lo[W-1:HALF]};
      end
      uifa_pkg::MD_SHIFT16: begin
        chk_sat = hi[W-1:16] != '0;
        chk_quo = chk_sat ? uifa_pkg::WORD_MAX : {hi[15:0], lo[W-1:16]};
      end
      default: begin
        chk_sat = 1'b0;
        chk_quo = '0;
      end
    endcase
  end

  assign div_needed = (mode == uifa_pkg::MD_GENERAL) && (div != '0) && (hi < div);

  // one restoring step; remainder stays below div, so 66 bits cover it
  assign shifted = {hi[W-2:0], lo[W-1]};
  assign diff    = {1'b0, hi[W-1], shifted} - {2'b00, div};
  assign ge      = ~diff[W+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= uifa_pkg::MDS_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      uifa_pkg::MDS_IDLE:  if (req.start) state_next = uifa_pkg::MDS_MUL;
      uifa_pkg::MDS_MUL:   if (mcnt == MUL_LAST) state_next = uifa_pkg::MDS_CHECK;
      uifa_pkg::MDS_CHECK: state_next = div_needed ? uifa_pkg::MDS_DIV : uifa_pkg::MDS_IDLE;
      uifa_pkg::MDS_DIV:   if (dcnt == DIV_LAST) state_next = uifa_pkg::MDS_IDLE;
      default:             state_next = uifa_pkg::MDS_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mcnt <= '0;
      dcnt <= '0;
      rsp  <= '0;
    end else begin
      rsp <= '0;
      case (state)
        uifa_pkg::MDS_IDLE: mcnt <= '0;
        uifa_pkg::MDS_MUL: begin
          mcnt <= mcnt + 3'd1;
          dcnt <= '0;
        end
        uifa_pkg::MDS_CHECK: begin
          if (!div_needed) begin
            rsp.done <= 1'b1;
            rsp.sat  <= chk_sat;
          end
        end
        uifa_pkg::MDS_DIV: begin
          dcnt <= dcnt + 6'd1;
          if (dcnt == DIV_LAST) rsp.done <= 1'b1;
        end
        default: mcnt <= '0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      uifa_pkg::MDS_IDLE: begin
        if (req.start) begin
          opa  <= a;
          opb  <= b;
          div  <= d;
          mode <= req.mode;
          hi   <= '0;
          lo   <= '0;
        end
      end
      uifa_pkg::MDS_MUL: begin
        if (mcnt != MUL_LAST) begin
          pp     <= pp_prod;
          pp_idx <= mcnt[1:0];
        end
        if (mcnt != '0) {hi, lo} <= {hi, lo} + pp_wide;
      end
      uifa_pkg::MDS_CHECK: begin
        if (!div_needed) quo <= chk_quo;
      end
      uifa_pkg::MDS_DIV: begin
        hi <= ge ? diff[W-1:0] : shifted;
        lo <= {lo[W-2:0], ge};
        if (dcnt == DIV_LAST) quo <= {lo[W-2:0], ge};
      end
      default: quo <= quo;
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/uifa_accum.sv =====
// Six saturating signed Q32.32 accumulators for the symmetric matrix.
// Depends on uifa_pkg.
`default_nettype none

module uifa_accum (
  input  logic                        clk,
  input  logic                        rst,
  input  uifa_pkg::acc_cmd_t          cmd,
  input  logic [uifa_pkg::WORD_W-2:0] term,
  output uifa_pkg::fisher_t           acc,
  output logic                        sat
);

  localparam int W = uifa_pkg::WORD_W;

  logic [W:0]   cur, sum;
  logic         ovf;
  logic [W-1:0] acc_new;

  always_comb begin
    cur = {acc[cmd.slot][W-1], acc[cmd.slot]};
    sum = cmd.neg ? cur - {2'b00, term} : cur + {2'b00, term};
    ovf = sum[W] != sum[W-1];
    if (ovf) begin
      acc_new = sum[W] ? uifa_pkg::ACC_MIN : uifa_pkg::MAG_MAX;
    end else begin
      acc_new = sum[W-1:0];
    end
    sat = cmd.add && ovf;
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.clr) begin
      acc <= '0;
    end else if (cmd.add) begin
      acc[cmd.slot] <= acc_new;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/uifa_checker.sv =====
// Port-level checker for the Fisher accumulator, bound to the top level.
// Depends on assert_macros.svh.
`default_nettype none

`include "assert_macros.svh"

module uifa_checker (
  input logic        clk,
  input logic        rst,
  input logic        pt_valid,
  input logic        pt_ready,
  input logic        fi_valid,
  input logic        fi_ready,
  input logic [63:0] fi_m_vv,
  input logic [63:0] fi_m_vkm,
  input logic [63:0] fi_m_vkiu,
  input logic [63:0] fi_m_kmkm,
  input logic [63:0] fi_m_kmkiu,
  input logic [63:0] fi_m_kiukiu,
  input logic        fi_saturated
);

  // result beat held while stalled
  `ASSERT_NEXT(a_res_hold, clk, rst, fi_valid && !fi_ready, fi_valid, "result beat dropped")
  `ASSERT_NEXT(a_res_stable, clk, rst, fi_valid && !fi_ready, $stable(fi_m_vv) && $stable(fi_m_vkm) && $stable(fi_m_vkiu) && $stable(fi_m_kmkm) && $stable(fi_m_kmkiu) && $stable(fi_m_kiukiu) && $stable(fi_saturated), "result payload moved while stalled")
  // one point at a time: busy right after a point beat
  `ASSERT_NEXT(a_busy_after_point, clk, rst, pt_valid && pt_ready, !pt_ready, "point taken while busy")
  // a new matrix only shows as the sequencer returns to idle
  `ASSERT_NOW(a_emit_to_idle, clk, rst, $rose(fi_valid), pt_ready, "result raised while busy")

endmodule

bind uncomp_inhibition_fisher_accum uifa_checker u_checker (
  .clk          (clk),
  .rst          (rst),
  .pt_valid     (point.valid),
  .pt_ready     (point.ready),
  .fi_valid     (fisher.valid),
  .fi_ready     (fisher.ready),
  .fi_m_vv      (fisher.m_vv),
  .fi_m_vkm     (fisher.m_vkm),
  .fi_m_vkiu    (fisher.m_vkiu),
  .fi_m_kmkm    (fisher.m_kmkm),
  .fi_m_kmkiu   (fisher.m_kmkiu),
  .fi_m_kiukiu  (fisher.m_kiukiu),
  .fi_saturated (fisher.saturated)
);

`default_nettype wire
